### sv/ibum_pkg.sv
package ibum_pkg;

    // Frame geometry
    localparam int MAX_DIM = 256;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CNT_W   = ADDR_W + 1;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_PASSES    = 3'd2;
    localparam logic [2:0] REG_WEIGHT    = 3'd3;
    localparam logic [2:0] REG_AMOUNT    = 3'd4;
    localparam logic [2:0] REG_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
        logic       status;
    } t_out_item;

    // Channel 2 red, 1 green, 0 blue
    typedef logic [2:0][7:0] t_pix;

    typedef struct packed {
        logic [8:0]  frame_width;
        logic [8:0]  frame_height;
        logic [5:0]  blur_passes;
        logic [14:0] blur_weight;
        logic [11:0] sharpen_amount;
        logic [7:0]  sharpen_threshold;
        logic        output_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        BUF_SRC,
        BUF_W0,
        BUF_W1
    } t_buf;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_C,
        ACC_ADD
    } t_acc;

    typedef struct packed {
        logic              load_we;
        logic [ADDR_W-1:0] load_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        t_buf              src_buf;
        t_acc              acc;
        logic              mul_en;
        logic              wr_en;
        logic              wr_buf;
        logic [ADDR_W-1:0] wr_addr;
        logic              border;
        logic              out_load;
        logic              out_zero;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

### sv/ibum_ctrl.sv
module ibum_ctrl import ibum_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    input  logic     i_req_type,
    output logic     o_in_ready,
    input  t_stat    i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLUR,
        S_MUL,
        S_WR,
        S_RDC
    } t_state;

    t_state             r_state, n_state;
    logic               r_phase, n_phase;
    logic [CNT_W-1:0]   r_lc, n_lc;
    logic [CNT_W-1:0]   r_rc, n_rc;
    logic [5:0]         r_pass, n_pass;
    logic [5:0]         r_npass, n_npass;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [ADDR_W-1:0]  r_i, n_i;
    logic [2:0]         r_step, n_step;
    logic [DIM_W-1:0]   r_bw, n_bw;
    logic [DIM_W-1:0]   r_bh, n_bh;
    logic               r_dst, n_dst;
    t_buf               r_src, n_src;
    t_buf               r_res, n_res;
    logic               r_last, n_last;

    logic [DIM_W-1:0]   eff_w, eff_h;
    logic [2*DIM_W-1:0] prod_total;
    logic [CNT_W-1:0]   total, lc_inc, idx;
    logic               fire, border, x_end, y_end, last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v);
        logic [DIM_W-1:0] res;
        res = DIM_W'(v);
        if (v < 9'd3) res = DIM_W'(3);
        else if (DIM_W'(v) > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
        return res;
    endfunction

    always_comb begin
        eff_w      = clamp_dim(i_cfg.frame_width);
        eff_h      = clamp_dim(i_cfg.frame_height);
        prod_total = eff_w * eff_h;
        total      = prod_total[CNT_W-1:0];
        lc_inc     = r_lc + CNT_W'(1);
        idx        = (r_rc < total) ? r_rc : total - CNT_W'(1);
        last       = (idx + CNT_W'(1)) >= total;
        x_end      = {1'b0, r_x} == r_bw - DIM_W'(1);
        y_end      = {1'b0, r_y} == r_bh - DIM_W'(1);
        border     = (r_x == '0) || (r_y == '0) || x_end || y_end;
    end

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_lc = r_lc; n_rc = r_rc;
        n_pass = r_pass; n_npass = r_npass; n_x = r_x; n_y = r_y; n_i = r_i;
        n_step = r_step; n_bw = r_bw; n_bh = r_bh; n_dst = r_dst;
        n_src = r_src; n_res = r_res; n_last = r_last;
        o_cmd = '0;
        o_cmd.src_buf = r_src;
        o_in_ready = (r_state == S_IDLE) && !i_stat.out_busy;
        fire = i_in_valid && o_in_ready;

        case (r_state)
            S_IDLE: begin
                if (fire && i_req_type == REQ_LOAD && !r_phase) begin
                    if (r_lc < total) begin
                        o_cmd.load_we   = 1'b1;
                        o_cmd.load_addr = r_lc[ADDR_W-1:0];
                    end
                    n_lc = lc_inc;
                    // Frame complete: latch geometry and kick off the passes, or go to read-out if none
                    if (r_lc >= total || lc_inc >= total) begin
                        n_lc = '0;
                        n_rc = '0;
                        n_bw = eff_w;
                        n_bh = eff_h;
                        n_npass = i_cfg.blur_passes;
                        if (i_cfg.blur_passes == 6'd0) begin
                            n_res   = BUF_SRC;
                            n_phase = 1'b1;
                        end else begin
                            n_pass  = '0;
                            n_src   = BUF_SRC;
                            n_dst   = 1'b0;
                            n_x     = '0;
                            n_y     = '0;
                            n_i     = '0;
                            n_step  = '0;
                            n_state = S_BLUR;
                        end
                    end
                end else if (fire && i_req_type == REQ_READ) begin
                    if (!r_phase) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_zero = 1'b1;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_addr = idx[ADDR_W-1:0];
                        o_cmd.src_buf = r_res;
                        n_last        = last;
                        n_lc          = '0;
                        if (last) begin
                            n_phase = 1'b0;
                            n_rc    = '0;
                        end else begin
                            n_rc = r_rc + CNT_W'(1);
                        end
                        n_state = S_RDC;
                    end
                end
            end
            S_RDC: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = r_last;
                n_state = S_IDLE;
            end
            S_BLUR: begin
                // Fetch center, up, down, left, right (center only on the border); data lands next cycle
                case (r_step)
                    3'd0:    o_cmd.rd_addr = r_i;
                    3'd1:    o_cmd.rd_addr = r_i - ADDR_W'(r_bw);
                    3'd2:    o_cmd.rd_addr = r_i + ADDR_W'(r_bw);
                    3'd3:    o_cmd.rd_addr = r_i - ADDR_W'(1);
                    3'd4:    o_cmd.rd_addr = r_i + ADDR_W'(1);
                    default: o_cmd.rd_addr = r_i;
                endcase
                o_cmd.rd_en = (r_step == 3'd0) || (!border && r_step <= 3'd4);
                if (r_step == 3'd1) o_cmd.acc = ACC_C;
                else if (r_step >= 3'd2) o_cmd.acc = ACC_ADD;
                n_step = r_step + 3'd1;
                if (border && r_step == 3'd1) n_state = S_WR;
                else if (r_step == 3'd5) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_buf  = r_dst;
                o_cmd.wr_addr = r_i;
                o_cmd.border  = border;
                n_step  = '0;
                n_state = S_BLUR;
                n_i     = r_i + ADDR_W'(1);
                if (!x_end) begin
                    n_x = r_x + COORD_W'(1);
                end else begin
                    n_x = '0;
                    if (!y_end) begin
                        n_y = r_y + COORD_W'(1);
                    end else begin
                        n_y = '0;
                        n_i = '0;
                        if (r_pass == r_npass - 6'd1) begin
                            n_res   = r_dst ? BUF_W1 : BUF_W0;
                            n_phase = 1'b1;
                            n_rc    = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_pass = r_pass + 6'd1;
                            n_src  = r_dst ? BUF_W1 : BUF_W0;
                            n_dst  = !r_dst;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_lc    <= '0;
            r_rc    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_lc    <= n_lc;
            r_rc    <= n_rc;
            r_step  <= n_step;
        end
        r_pass  <= n_pass;
        r_npass <= n_npass;
        r_x     <= n_x;
        r_y     <= n_y;
        r_i     <= n_i;
        r_bw    <= n_bw;
        r_bh    <= n_bh;
        r_dst   <= n_dst;
        r_src   <= n_src;
        r_res   <= n_res;
        r_last  <= n_last;
    end

endmodule

### sv/ibum_dp.sv
module ibum_dp import ibum_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    output t_stat     o_stat
);

    t_pix m_src [DEPTH];
    t_pix m_w0  [DEPTH];
    t_pix m_w1  [DEPTH];

    t_pix r_q_s, r_q0, r_q1;
    t_buf r_sel;
    t_pix q_blur, wr_pix, sharp;

    logic [2:0][7:0]         r_c;
    logic [2:0][9:0]         r_sum;
    logic signed [2:0][27:0] r_prod;
    t_out_item               r_out;
    logic                    r_ov;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we)
            m_src[i_cmd.load_addr] <= {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};
        if (i_cmd.wr_en && !i_cmd.wr_buf) m_w0[i_cmd.wr_addr] <= wr_pix;
        if (i_cmd.wr_en && i_cmd.wr_buf)  m_w1[i_cmd.wr_addr] <= wr_pix;
        if (i_cmd.rd_en) begin
            r_q_s <= m_src[i_cmd.rd_addr];
            r_q0  <= m_w0[i_cmd.rd_addr];
            r_q1  <= m_w1[i_cmd.rd_addr];
            r_sel <= i_cmd.src_buf;
        end
    end

    always_comb begin
        case (r_sel)
            BUF_SRC: q_blur = r_q_s;
            BUF_W0:  q_blur = r_q0;
            BUF_W1:  q_blur = r_q1;
            default: q_blur = r_q_s;
        endcase
    end

    // Smoothing arithmetic and sharpen, per channel
    always_comb begin
        logic signed [12:0] tmp;
        logic signed [8:0]  d;
        logic [8:0]         mag9;
        logic [19:0]        gain;
        logic signed [13:0] v;
        logic [7:0]         o;
        logic [7:0]         b;
        for (int k = 0; k < 3; k++) begin
            tmp = $signed({5'b0, r_c[k]}) + 13'($signed(r_prod[k][27:16]));
            if (i_cmd.border)      wr_pix[k] = r_c[k];
            else if (tmp < 0)      wr_pix[k] = 8'd0;
            else if (tmp > 13'sd255) wr_pix[k] = 8'd255;
            else                   wr_pix[k] = tmp[7:0];

            o    = r_q_s[k];
            b    = q_blur[k];
            d    = $signed({1'b0, o}) - $signed({1'b0, b});
            mag9 = d[8] ? 9'(-d) : 9'(d);
            gain = i_cfg.sharpen_amount * mag9[7:0];
            if (d[8]) v = $signed({6'b0, o}) - $signed({2'b0, gain[19:8]});
            else      v = $signed({6'b0, o}) + $signed({2'b0, gain[19:8]});
            if (mag9[7:0] <= i_cfg.sharpen_threshold) sharp[k] = o;
            else if (v < 0)                           sharp[k] = 8'd0;
            else if (v > 14'sd255)                    sharp[k] = 8'd255;
            else                                      sharp[k] = v[7:0];
            if (!i_cfg.output_mode) sharp[k] = b;
        end
    end

    // Accumulate neighbors, then scale the Laplacian
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            case (i_cmd.acc)
                ACC_C: begin
                    r_c[k]   <= q_blur[k];
                    r_sum[k] <= '0;
                end
                ACC_ADD: r_sum[k] <= r_sum[k] + 10'(q_blur[k]);
                default: ;
            endcase
            if (i_cmd.mul_en)
                r_prod[k] <= $signed({1'b0, i_cfg.blur_weight})
                           * ($signed({2'b0, r_sum[k]}) - $signed({2'b0, r_c[k], 2'b00}));
        end
    end

    // Output register: load a result, drop it when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                r_out <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                           last_pixel: 1'b0, status: 1'b1};
            end else begin
                r_out <= '{red_out: sharp[2], green_out: sharp[1], blue_out: sharp[0],
                           last_pixel: i_cmd.out_last, status: 1'b0};
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_item      = r_out;
    assign o_stat.out_busy = r_ov && !i_out_ready;

endmodule

### sv/iterative_blur_unsharp_mask.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg       input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A load beat writes the source memory; a read beat's result is read from memory, then
// sharpened into the output register; a read while loading gives a zero status beat.
// After the last load the smoothing passes run from the pixel memories through one read
// port, fetching four neighbors per interior pixel; border pixels are copied as is.
// Reset (synchronous, active low) clears the controller and the output valid.
// No beat is accepted while a result is stalled at the output or the passes run.
module iterative_blur_unsharp_mask import ibum_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width       <= 9'd256;
            r_cfg.frame_height      <= 9'd256;
            r_cfg.blur_passes       <= 6'd1;
            r_cfg.blur_weight       <= 15'd6554;
            r_cfg.sharpen_amount    <= 12'd256;
            r_cfg.sharpen_threshold <= 8'd0;
            r_cfg.output_mode       <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_WIDTH:     r_cfg.frame_width       <= pwdata[8:0];
                REG_HEIGHT:    r_cfg.frame_height      <= pwdata[8:0];
                REG_PASSES:    r_cfg.blur_passes       <= pwdata[5:0];
                REG_WEIGHT:    r_cfg.blur_weight       <= pwdata[14:0];
                REG_AMOUNT:    r_cfg.sharpen_amount    <= pwdata[11:0];
                REG_THRESHOLD: r_cfg.sharpen_threshold <= pwdata[7:0];
                REG_MODE:      r_cfg.output_mode       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[4:2])
            REG_WIDTH:     prdata = 32'(r_cfg.frame_width);
            REG_HEIGHT:    prdata = 32'(r_cfg.frame_height);
            REG_PASSES:    prdata = 32'(r_cfg.blur_passes);
            REG_WEIGHT:    prdata = 32'(r_cfg.blur_weight);
            REG_AMOUNT:    prdata = 32'(r_cfg.sharpen_amount);
            REG_THRESHOLD: prdata = 32'(r_cfg.sharpen_threshold);
            REG_MODE:      prdata = 32'(r_cfg.output_mode);
            default:       prdata = 32'd0;
        endcase
    end

    ibum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ibum_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_stat      (stat)
    );

endmodule

### sv/ibum_checker.sv
module ibum_checker import ibum_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_item,
    input logic        pready
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // An early read carries zeros only
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |->
            o_out_item.red_out == 8'd0 && o_out_item.green_out == 8'd0 &&
            o_out_item.blue_out == 8'd0 && !o_out_item.last_pixel)
        else $error("status beat with nonzero payload");

    // No input beat while a result is stalled
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted with result stalled");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("register port not ready");

endmodule

bind iterative_blur_unsharp_mask ibum_checker u_ibum_checker (.*);
